// ----- rtl/core/attention_group_packer_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the attention group packer
// Shared property forms; each expands to one labelled concurrent assertion.
// ----------------------------------------------------------------------------
`ifndef ATTENTION_GROUP_PACKER_DEFINES_SVH
`define ATTENTION_GROUP_PACKER_DEFINES_SVH

// antecedent holds -> consequent holds on the same edge
`define AGP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("agp assertion failed");

// antecedent holds -> consequent holds on the next edge
`define AGP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("agp assertion failed");

`endif

// ----- rtl/core/agp_pkg.sv -----
// ----------------------------------------------------------------------------
// agp_pkg
// Widths, register indexes, limits and shared types of the group packer.
// ----------------------------------------------------------------------------
package agp_pkg;

    localparam int MAX_ROWS       = 256;
    localparam int MAX_ROW_TOKENS = 512;

    localparam int ROW_W   = $clog2(MAX_ROWS);
    localparam int END_W   = ROW_W + 1;
    localparam int CNT_W   = 10;
    localparam int OFF_W   = 17;
    localparam int TOK_W   = 13;
    localparam int OVH_W   = 12;
    localparam int SQ_W    = 19;                 // one row's token count squared
    localparam int COST_W  = 22;                 // sum of squares inside a group
    localparam int MPROD_W = 2 * TOK_W;
    localparam int CPROD_W = OVH_W + COST_W;
    localparam int SCALE_SH = 8;                 // Q4.8 ratio

    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_TOKENS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_OVH    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GROUP_EN   = 2'd2;

    localparam logic [TOK_W-1:0] RST_MAX_TOKENS = 13'd96;
    localparam logic [OVH_W-1:0] RST_MAX_OVH    = 12'd461;

    localparam logic [TOK_W-1:0] LIM_TOK_MIN    = 13'd1;
    localparam logic [TOK_W-1:0] LIM_TOK_MAX    = 13'd4096;
    localparam logic [OVH_W-1:0] LIM_OVH_MIN    = 12'd256;
    localparam logic [CNT_W-1:0] ROW_TOKENS_MAX = CNT_W'(MAX_ROW_TOKENS);
    localparam logic [ROW_W-1:0] ROW_LAST       = ROW_W'(MAX_ROWS - 1);

    localparam int OUTQ_DEPTH = 2;
    localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
    localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

    typedef struct packed {
        logic [ROW_W-1:0] begin_index;
        logic [END_W-1:0] end_index;
        logic [OFF_W-1:0] start_offset;
        logic [TOK_W-1:0] token_total;
        logic             mask_required;
        logic             final_group;
    } agp_res_t;

    typedef struct packed {
        logic load;       // capture an accepted row
        logic calc;       // register merged totals and products
        logic commit;     // update group state, hold the second result
        logic push;       // write a result into the output queue
        logic push_sel;   // 0: first result, 1: held second result
    } agp_cmd_t;

    typedef struct packed {
        logic has_first;
        logic has_second;
    } agp_stat_t;

endpackage

// ----- rtl/core/attention_group_packer.sv -----
// ----------------------------------------------------------------------------
// attention_group_packer
// Greedy merge of batch rows into attention groups, one row per transaction.
// ----------------------------------------------------------------------------
// One row is taken at a time. Its token count (saturated at 512) either joins
// the open group or closes it and opens a new one; a row joins only while the
// merged total stays within max_group_tokens and total^2 * 256 stays within
// max_overhead_q8 times the summed squared row counts. Empty rows inside a
// group are absorbed, empty rows outside one are skipped, and with grouping
// off each non-empty row is a group of its own. The last row (or row 255)
// flushes the open group with final_group set and restarts row numbering.
// After acceptance a row goes through capture with the row's square, a stage
// holding the two products of the overhead test, then the compare and state
// update, before the next row can be accepted. A row that produces two groups
// also pushes the held second result. Results go through a two-entry queue,
// so an output stall only holds the block once it is full. Configuration
// writes are accepted every cycle and must only be made while idle.
// ----------------------------------------------------------------------------
module attention_group_packer import agp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,

    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [CNT_W-1:0]     token_count,
    input  logic [OFF_W-1:0]     row_offset,
    input  logic                 last_row,

    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [ROW_W-1:0]     begin_index,
    output logic [END_W-1:0]     end_index,
    output logic [OFF_W-1:0]     start_offset,
    output logic [TOK_W-1:0]     token_total,
    output logic                 mask_required,
    output logic                 final_group
);

    agp_cmd_t  cmd;
    agp_stat_t stat;
    agp_res_t  push_data;
    agp_res_t  out_data;
    logic      fifo_full;

    assign cfg_ready = 1'b1;

    agp_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .fifo_full (fifo_full),
        .stat      (stat),
        .cmd       (cmd)
    );

    agp_datapath u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .token_count (token_count),
        .row_offset  (row_offset),
        .last_row    (last_row),
        .push_data   (push_data)
    );

    agp_outq u_outq
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cmd.push),
        .push_data (push_data),
        .full      (fifo_full),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    assign begin_index   = out_data.begin_index;
    assign end_index     = out_data.end_index;
    assign start_offset  = out_data.start_offset;
    assign token_total   = out_data.token_total;
    assign mask_required = out_data.mask_required;
    assign final_group   = out_data.final_group;

endmodule

// ----- rtl/core/agp_ctrl.sv -----
// ----------------------------------------------------------------------------
// agp_ctrl
// Sequencer: row capture, product stage, decision, second result push.
// ----------------------------------------------------------------------------
module agp_ctrl import agp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  logic      fifo_full,
    input  agp_stat_t stat,
    output agp_cmd_t  cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CALC  = 2'd1;
    localparam logic [1:0] ST_DEC   = 2'd2;
    localparam logic [1:0] ST_PUSH1 = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                cmd.calc   = 1'b1;
                state_next = ST_DEC;
            end
            ST_DEC:
            begin
                if (!stat.has_first)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (!fifo_full)
                begin
                    cmd.commit = 1'b1;
                    cmd.push   = 1'b1;
                    state_next = stat.has_second ? ST_PUSH1 : ST_IDLE;
                end
            end
            ST_PUSH1:
            begin
                if (!fifo_full)
                begin
                    cmd.push     = 1'b1;
                    cmd.push_sel = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ----- rtl/core/agp_datapath.sv -----
// ----------------------------------------------------------------------------
// agp_datapath
// Configuration registers, open group state, limit tests and result building.
// ----------------------------------------------------------------------------
module agp_datapath import agp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  agp_cmd_t             cmd,
    output agp_stat_t            stat,
    input  logic                 cfg_valid,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic [CNT_W-1:0]     token_count,
    input  logic [OFF_W-1:0]     row_offset,
    input  logic                 last_row,
    output agp_res_t             push_data
);

    // configuration
    logic [TOK_W-1:0] max_tok_reg;
    logic [OVH_W-1:0] max_ovh_reg;
    logic             group_en_reg;

    // captured row
    logic [CNT_W-1:0] t_reg;
    logic [SQ_W-1:0]  t2_reg;
    logic [OFF_W-1:0] off_reg;
    logic             last_reg;

    // product stage
    logic [TOK_W-1:0]   merged_reg;
    logic [COST_W-1:0]  cost_reg;
    logic [MPROD_W-1:0] mprod_reg;
    logic [CPROD_W-1:0] cprod_reg;

    // group state
    logic              open_reg;
    logic [ROW_W-1:0]  row_cnt_reg;
    logic [ROW_W-1:0]  open_begin_reg;
    logic [END_W-1:0]  open_end_reg;
    logic [OFF_W-1:0]  open_off_reg;
    logic [TOK_W-1:0]  open_tok_reg;
    logic [COST_W-1:0] open_cost_reg;
    logic              open_multi_reg;

    agp_res_t hold_reg;

    logic [CNT_W-1:0]   t_sat;
    logic [SQ_W-1:0]    t_sq_full;
    logic [TOK_W-1:0]   lim_tok;
    logic [OVH_W-1:0]   lim_ovh;
    logic [TOK_W-1:0]   merged;
    logic [COST_W-1:0]  cost;

    logic              open_eff;
    logic              flush;
    logic              nonzero;
    logic              too_big;
    logic              too_costly;
    logic              brk;
    logic              single_emit;
    logic              final_emit;
    logic              old_emit;
    logic              new_emit;
    logic [END_W-1:0]  row_end;

    logic              open_next;
    logic [ROW_W-1:0]  open_begin_next;
    logic [END_W-1:0]  open_end_next;
    logic [OFF_W-1:0]  open_off_next;
    logic [TOK_W-1:0]  open_tok_next;
    logic [COST_W-1:0] open_cost_next;
    logic              open_multi_next;
    logic [ROW_W-1:0]  row_cnt_next;

    agp_res_t res_old;
    agp_res_t res_new;
    agp_res_t res0;

    always_comb
    begin
        t_sat     = (token_count > ROW_TOKENS_MAX) ? ROW_TOKENS_MAX : token_count;
        t_sq_full = SQ_W'(t_sat) * SQ_W'(t_sat);

        if (max_tok_reg == '0)
            lim_tok = LIM_TOK_MIN;
        else if (max_tok_reg > LIM_TOK_MAX)
            lim_tok = LIM_TOK_MAX;
        else
            lim_tok = max_tok_reg;
        lim_ovh = (max_ovh_reg < LIM_OVH_MIN) ? LIM_OVH_MIN : max_ovh_reg;

        merged = open_tok_reg + TOK_W'(t_reg);
        cost   = open_cost_reg + COST_W'(t2_reg);
    end

    // decision on the registered products
    always_comb
    begin
        open_eff    = open_reg && group_en_reg;
        flush       = open_reg && !group_en_reg;
        nonzero     = (t_reg != '0);
        too_big     = (merged_reg > lim_tok);
        too_costly  = (CPROD_W'({mprod_reg, {SCALE_SH{1'b0}}}) > cprod_reg);
        brk         = open_eff && nonzero && (too_big || too_costly);
        row_end     = END_W'(row_cnt_reg) + END_W'(1);
        single_emit = 1'b0;

        open_next       = open_eff;
        open_begin_next = open_begin_reg;
        open_end_next   = open_end_reg;
        open_off_next   = open_off_reg;
        open_tok_next   = open_tok_reg;
        open_cost_next  = open_cost_reg;
        open_multi_next = open_multi_reg;

        if (open_eff)
        begin
            if (!nonzero)
            begin
                open_end_next = row_end;
            end
            else if (brk)
            begin
                open_begin_next = row_cnt_reg;
                open_end_next   = row_end;
                open_off_next   = off_reg;
                open_tok_next   = TOK_W'(t_reg);
                open_cost_next  = COST_W'(t2_reg);
                open_multi_next = 1'b0;
            end
            else
            begin
                open_end_next   = row_end;
                open_tok_next   = merged_reg;
                open_cost_next  = cost_reg;
                open_multi_next = 1'b1;
            end
        end
        else if (nonzero)
        begin
            if (group_en_reg)
            begin
                open_next       = 1'b1;
                open_begin_next = row_cnt_reg;
                open_end_next   = row_end;
                open_off_next   = off_reg;
                open_tok_next   = TOK_W'(t_reg);
                open_cost_next  = COST_W'(t2_reg);
                open_multi_next = 1'b0;
            end
            else
            begin
                single_emit = 1'b1;
            end
        end

        final_emit = last_reg && open_next;
        if (last_reg)
            open_next = 1'b0;
        row_cnt_next = last_reg ? '0 : row_end[ROW_W-1:0];

        res_old.begin_index   = open_begin_reg;
        res_old.end_index     = open_end_reg;
        res_old.start_offset  = open_off_reg;
        res_old.token_total   = open_tok_reg;
        res_old.mask_required = open_multi_reg;
        res_old.final_group   = 1'b0;

        if (single_emit)
        begin
            res_new.begin_index   = row_cnt_reg;
            res_new.end_index     = row_end;
            res_new.start_offset  = off_reg;
            res_new.token_total   = TOK_W'(t_reg);
            res_new.mask_required = 1'b0;
            res_new.final_group   = last_reg;
        end
        else
        begin
            res_new.begin_index   = open_begin_next;
            res_new.end_index     = open_end_next;
            res_new.start_offset  = open_off_next;
            res_new.token_total   = open_tok_next;
            res_new.mask_required = open_multi_next;
            res_new.final_group   = 1'b1;
        end

        old_emit = flush || brk;
        new_emit = single_emit || final_emit;
        res0     = old_emit ? res_old : res_new;

        stat.has_first  = old_emit || new_emit;
        stat.has_second = old_emit && new_emit;
        push_data       = cmd.push_sel ? hold_reg : res0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_tok_reg  <= RST_MAX_TOKENS;
            max_ovh_reg  <= RST_MAX_OVH;
            group_en_reg <= 1'b1;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_MAX_TOKENS: max_tok_reg  <= cfg_data;
                CFG_MAX_OVH:    max_ovh_reg  <= cfg_data[OVH_W-1:0];
                CFG_GROUP_EN:   group_en_reg <= cfg_data[0];
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            t_reg    <= t_sat;
            t2_reg   <= t_sq_full;
            off_reg  <= row_offset;
            last_reg <= last_row || (row_cnt_reg == ROW_LAST);
        end
        if (cmd.calc)
        begin
            merged_reg <= merged;
            cost_reg   <= cost;
            mprod_reg  <= MPROD_W'(merged) * MPROD_W'(merged);
            cprod_reg  <= CPROD_W'(lim_ovh) * CPROD_W'(cost);
        end
        if (cmd.commit)
            hold_reg <= res_new;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg       <= 1'b0;
            row_cnt_reg    <= '0;
            open_begin_reg <= '0;
            open_end_reg   <= '0;
            open_off_reg   <= '0;
            open_tok_reg   <= '0;
            open_cost_reg  <= '0;
            open_multi_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            open_reg       <= open_next;
            row_cnt_reg    <= row_cnt_next;
            open_begin_reg <= open_begin_next;
            open_end_reg   <= open_end_next;
            open_off_reg   <= open_off_next;
            open_tok_reg   <= open_tok_next;
            open_cost_reg  <= open_cost_next;
            open_multi_reg <= open_multi_next;
        end
    end

endmodule

// ----- rtl/core/agp_outq.sv -----
// ----------------------------------------------------------------------------
// agp_outq
// Small result queue between the decision stage and the output channel.
// ----------------------------------------------------------------------------
module agp_outq import agp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  agp_res_t push_data,
    output logic     full,
    output logic     out_valid,
    input  logic     out_ready,
    output agp_res_t out_data
);

    agp_res_t              entry_reg [OUTQ_DEPTH];
    logic [OUTQ_PTR_W-1:0] wr_ptr_reg;
    logic [OUTQ_PTR_W-1:0] rd_ptr_reg;
    logic [OUTQ_CNT_W-1:0] count_reg;
    logic                  pop;

    assign out_valid = (count_reg != '0);
    assign full      = (count_reg == OUTQ_CNT_W'(OUTQ_DEPTH));
    assign pop       = out_valid && out_ready;
    assign out_data  = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + OUTQ_PTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + OUTQ_PTR_W'(1);
            if (push && !pop)
                count_reg <= count_reg + OUTQ_CNT_W'(1);
            else if (pop && !push)
                count_reg <= count_reg - OUTQ_CNT_W'(1);
        end
    end

endmodule

// ----- rtl/core/agp_checker.sv -----
// ----------------------------------------------------------------------------
// agp_checker
// Port-level checks on the group packer, bound to the top level.
// ----------------------------------------------------------------------------
`include "attention_group_packer_defines.svh"

module agp_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [7:0]  begin_index,
    input logic [8:0]  end_index,
    input logic [16:0] start_offset,
    input logic [12:0] token_total,
    input logic        mask_required,
    input logic        final_group
);

    // a stalled result must not move
    `AGP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(begin_index) && $stable(end_index) && $stable(start_offset) && $stable(token_total) && $stable(mask_required) && $stable(final_group))

    // one row in flight: no back-to-back acceptance
    `AGP_ASSERT_NEXT(a_one_row, clk, rst_n, in_valid && in_ready, !in_ready)

    // every group spans at least one row and carries tokens
    `AGP_ASSERT_NOW(a_group_shape, clk, rst_n, out_valid, (token_total != 13'd0) && (end_index > {1'b0, begin_index}))

    // a masked group covers at least two rows
    `AGP_ASSERT_NOW(a_mask_rows, clk, rst_n, out_valid && mask_required, end_index > ({1'b0, begin_index} + 9'd1))

endmodule

bind attention_group_packer agp_checker u_agp_checker (.*);

// ----- dv/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// attention_group_packer testbench
// Feeds batch rows through the valid/ready input and predicts every emitted
// group in step with each accepted transaction. Groups coming out are checked
// field by field in order. Phases change the limits and grouping mode while
// the block is idle, and vary the idling of both sides, with one long output
// hold-off that backs the block up into its input.
// ----------------------------------------------------------------------------
module testbench;
    import agp_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;   // unmapped index
    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_CYCLES   = 400;
    localparam int LIMIT_CYCLES  = 400000;

    typedef struct {
        logic [CNT_W-1:0] count;
        logic [OFF_W-1:0] offset;
        logic             last;
    } row_item_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;

    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [CNT_W-1:0]     token_count = '0;
    logic [OFF_W-1:0]     row_offset = '0;
    logic                 last_row = 1'b0;

    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [ROW_W-1:0]     begin_index;
    logic [END_W-1:0]     end_index;
    logic [OFF_W-1:0]     start_offset;
    logic [TOK_W-1:0]     token_total;
    logic                 mask_required;
    logic                 final_group;

    attention_group_packer dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .token_count   (token_count),
        .row_offset    (row_offset),
        .last_row      (last_row),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .begin_index   (begin_index),
        .end_index     (end_index),
        .start_offset  (start_offset),
        .token_total   (token_total),
        .mask_required (mask_required),
        .final_group   (final_group)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // register shadow
    logic [TOK_W-1:0] lim_tokens_reg = RST_MAX_TOKENS;
    logic [OVH_W-1:0] lim_ovh_reg    = RST_MAX_OVH;
    logic             group_en_reg   = 1'b1;

    // packer state as the block should hold it
    logic             grp_open   = 1'b0;
    logic [END_W-1:0] next_row   = '0;
    logic [END_W-1:0] grp_begin  = '0;
    logic [END_W-1:0] grp_end    = '0;
    logic [OFF_W-1:0] grp_offset = '0;
    logic [TOK_W-1:0] grp_tokens = '0;
    logic [24:0]      grp_cost   = '0;
    logic [8:0]       grp_rows   = '0;

    row_item_t rows_pending[$];
    agp_res_t  groups_due[$];
    int        rows_queued   = 0;
    int        rows_accepted = 0;
    int        fail_count    = 0;
    int        cycle_count   = 0;
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;
    logic      hold_start = 1'b0;
    int        hold_left  = 0;

    function automatic void emit_group(logic [END_W-1:0] first, logic [END_W-1:0] past,
                                       logic [OFF_W-1:0] off, logic [TOK_W-1:0] tok,
                                       logic [8:0] rows, logic fin);
        agp_res_t g;
        g.begin_index   = first[ROW_W-1:0];
        g.end_index     = past;
        g.start_offset  = off;
        g.token_total   = tok;
        g.mask_required = (rows > 9'd1);
        g.final_group   = fin;
        groups_due.insert(groups_due.size(), g);
    endfunction

    function automatic void open_group(logic [END_W-1:0] row, logic [CNT_W-1:0] cnt,
                                       logic [OFF_W-1:0] off);
        grp_open   = 1'b1;
        grp_begin  = row;
        grp_end    = row + END_W'(1);
        grp_offset = off;
        grp_tokens = TOK_W'(cnt);
        grp_cost   = 25'(longint'(cnt) * longint'(cnt));
        grp_rows   = 9'd1;
    endfunction

    // one accepted row: advance the packer state and queue any groups it closes
    function automatic void pack_row(logic [CNT_W-1:0] cnt_in, logic [OFF_W-1:0] off,
                                     logic last_in);
        logic [CNT_W-1:0] cnt;
        logic [END_W-1:0] row;
        logic             last;
        longint unsigned  lim_tok;
        longint unsigned  lim_ovh;
        longint unsigned  merged;
        longint unsigned  cost;
        cnt  = (cnt_in > ROW_TOKENS_MAX) ? ROW_TOKENS_MAX : cnt_in;
        row  = next_row;
        last = last_in || (row >= END_W'(ROW_LAST));
        lim_tok = (lim_tokens_reg == 0) ? longint'(LIM_TOK_MIN) : longint'(lim_tokens_reg);
        if (lim_tok > longint'(LIM_TOK_MAX))
            lim_tok = longint'(LIM_TOK_MAX);
        lim_ovh = (lim_ovh_reg < LIM_OVH_MIN) ? longint'(LIM_OVH_MIN) : longint'(lim_ovh_reg);

        // grouping switched off with a group still open: flush it first
        if (grp_open && !group_en_reg)
        begin
            emit_group(grp_begin, grp_end, grp_offset, grp_tokens, grp_rows, 1'b0);
            grp_open = 1'b0;
        end

        if (grp_open)
        begin
            if (cnt == 0)
                grp_end = row + END_W'(1);
            else
            begin
                merged = longint'(grp_tokens) + longint'(cnt);
                cost   = longint'(grp_cost) + longint'(cnt) * longint'(cnt);
                if (merged > lim_tok || merged * merged * (1 << SCALE_SH) > lim_ovh * cost)
                begin
                    emit_group(grp_begin, grp_end, grp_offset, grp_tokens, grp_rows, 1'b0);
                    open_group(row, cnt, off);
                end
                else
                begin
                    grp_tokens = TOK_W'(merged);
                    grp_cost   = 25'(cost);
                    grp_end    = row + END_W'(1);
                    grp_rows   = grp_rows + 9'd1;
                end
            end
        end
        else if (cnt != 0)
        begin
            if (group_en_reg)
                open_group(row, cnt, off);
            else
                emit_group(row, row + END_W'(1), off, TOK_W'(cnt), 9'd1, last);
        end

        if (last)
        begin
            if (grp_open)
            begin
                emit_group(grp_begin, grp_end, grp_offset, grp_tokens, grp_rows, 1'b1);
                grp_open = 1'b0;
            end
            next_row = '0;
        end
        else
            next_row = row + END_W'(1);
    endfunction

    function automatic void check_field(string name, int unsigned exp_val,
                                        int unsigned act_val);
        if (exp_val != act_val)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_val, act_val);
            fail_count++;
        end
    endfunction

    // input driver
    always @(posedge clk or negedge rst_n)
    begin
        row_item_t nxt;
        if (!rst_n)
        begin
            in_valid    <= 1'b0;
            token_count <= '0;
            row_offset  <= '0;
            last_row    <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                pack_row(token_count, row_offset, last_row);
                rows_accepted++;
            end
            if (!in_valid || in_ready)
            begin
                if (rows_pending.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    nxt = rows_pending.pop_front();
                    in_valid    <= 1'b1;
                    token_count <= nxt.count;
                    row_offset  <= nxt.offset;
                    last_row    <= nxt.last;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // long output hold-off, counted down on its own
    always @(posedge clk)
    begin
        if (hold_start)
            hold_left <= HOLD_CYCLES;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end

    // group monitor
    always @(posedge clk)
    begin
        agp_res_t g;
        if (rst_n && out_valid && out_ready)
        begin
            if (groups_due.size() == 0)
            begin
                $error("group with none due: begin %0d end %0d tokens %0d",
                       begin_index, end_index, token_total);
                fail_count++;
            end
            else
            begin
                g = groups_due.pop_front();
                check_field("begin_index", 32'(g.begin_index), 32'(begin_index));
                check_field("end_index", 32'(g.end_index), 32'(end_index));
                check_field("start_offset", 32'(g.start_offset), 32'(start_offset));
                check_field("token_total", 32'(g.token_total), 32'(token_total));
                check_field("mask_required", 32'(g.mask_required), 32'(mask_required));
                check_field("final_group", 32'(g.final_group), 32'(final_group));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES)
        begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic void add_row(logic [CNT_W-1:0] cnt, logic [OFF_W-1:0] off, logic last);
        row_item_t r;
        r.count  = cnt;
        r.offset = off;
        r.last   = last;
        rows_pending.insert(rows_pending.size(), r);
        rows_queued++;
    endfunction

    // mostly small counts so that groups form; some empties and some saturating
    function automatic logic [CNT_W-1:0] rand_count();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 25)
            return '0;
        else if (pick < 75)
            return CNT_W'($urandom_range(1, 64));
        else if (pick < 90)
            return CNT_W'($urandom_range(65, 512));
        else
            return CNT_W'($urandom_range(0, 1023));
    endfunction

    function automatic void add_batch(int n);
        for (int i = 0; i < n; i++)
            add_row(rand_count(), OFF_W'($urandom_range(0, 131071)), i == n - 1);
    endfunction

    task automatic drain();
        do
            @(posedge clk);
        while (rows_accepted != rows_queued || groups_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_MAX_TOKENS: lim_tokens_reg = val[TOK_W-1:0];
            CFG_MAX_OVH:    lim_ovh_reg    = val[OVH_W-1:0];
            CFG_GROUP_EN:   group_en_reg   = val[0];
            default: ;
        endcase
    endtask

    task automatic set_limits(logic [CFG_W-1:0] tokens, logic [CFG_W-1:0] ovh, logic en,
                              int send_pct, int recv_pct);
        write_reg(CFG_MAX_TOKENS, tokens);
        write_reg(CFG_MAX_OVH, ovh);
        write_reg(CFG_GROUP_EN, CFG_W'(en));
        send_idle_pct  <= send_pct;
        recv_stall_pct <= recv_pct;
    endtask

    task automatic random_phase(int n_rows);
        int left;
        int len;
        left = n_rows;
        while (left > 0)
        begin
            len = $urandom_range(1, 12);
            if (len > left)
                len = left;
            add_batch(len);
            left -= len;
        end
        drain();
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // reset limits: 96 tokens, ratio 1.8
        add_row(10'd0,   17'd0,      1'b0);   // empty before any group: skipped
        add_row(10'd40,  17'd100,    1'b0);
        add_row(10'd0,   17'd200,    1'b0);   // absorbed
        add_row(10'd10,  17'd300,    1'b0);   // joins, mask needed
        add_row(10'd40,  17'd400,    1'b0);   // overhead too high
        add_row(10'd60,  17'd500,    1'b0);   // total too large
        add_row(10'd0,   17'd131071, 1'b1);   // empty last row flushes
        add_row(10'd0,   17'd0,      1'b1);   // empty last row, nothing open
        add_row(10'd1023, 17'd131071, 1'b1);  // saturates, alone
        add_row(10'd512, 17'd0,      1'b0);   // first row above the limit
        add_row(10'd1,   17'd5,      1'b0);
        add_row(10'd513, 17'd7,      1'b1);   // closes one, flushes another
        add_row(10'd5,   17'd9,      1'b0);   // left open across the next write
        drain();

        write_reg(CFG_GROUP_EN, CFG_W'(0));
        add_row(10'd7,   17'd11,     1'b1);   // open group goes out first
        add_row(10'd0,   17'd3,      1'b0);
        add_row(10'd700, 17'd12,     1'b0);
        add_row(10'd0,   17'd0,      1'b1);
        drain();

        set_limits(13'd96, 13'd461, 1'b1, 0, 0);
        random_phase(50);

        set_limits(13'd4096, 13'd4095, 1'b1, 85, 0);
        random_phase(40);

        write_reg(CFG_SPARE, 13'h1fff);
        set_limits(13'd0, 13'd0, 1'b1, 0, 85);
        random_phase(40);

        // long batch that runs into the row limit, under a long output hold
        set_limits(13'd8191, 13'd8191, 1'b1, 16, 16);
        for (int i = 0; i < 258; i++)
            add_row((($urandom_range(99) < 60) ? '0 : rand_count()),
                    OFF_W'($urandom_range(0, 131071)), i == 257);
        @(posedge clk);
        hold_start <= 1'b1;
        @(posedge clk);
        hold_start <= 1'b0;
        drain();

        set_limits(13'd4097, 13'd255, 1'b0, 16, 16);
        random_phase(30);

        set_limits(13'd300, 13'd600, 1'b1, 16, 16);
        random_phase(40);

        set_limits(13'd1, 13'd256, 1'b1, 0, 0);
        random_phase(20);

        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
